// ----- sv/grpf_pkg.sv -----
package grpf_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_ROWS  = 7;
	localparam int SLOT_W      = 4;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_DRAW  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Each entry packs the five glyph columns, column 0 in the low bits.
	localparam logic [34:0] FONT_ROM [16] = '{
		{7'h00, 7'h00, 7'h00, 7'h00, 7'h00},   // space and unsupported codes
		{7'h63, 7'h64, 7'h08, 7'h13, 7'h63},   // percent
		{7'h08, 7'h08, 7'h08, 7'h08, 7'h08},   // hyphen
		{7'h00, 7'h00, 7'h60, 7'h60, 7'h00},   // period
		{7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E},   // 0
		{7'h00, 7'h40, 7'h7F, 7'h42, 7'h00},   // 1
		{7'h46, 7'h49, 7'h51, 7'h61, 7'h42},   // 2
		{7'h31, 7'h4B, 7'h45, 7'h41, 7'h21},   // 3
		{7'h10, 7'h7F, 7'h12, 7'h14, 7'h18},   // 4
		{7'h39, 7'h45, 7'h45, 7'h45, 7'h27},   // 5
		{7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C},   // 6
		{7'h03, 7'h05, 7'h09, 7'h71, 7'h01},   // 7
		{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},   // 8
		{7'h1E, 7'h29, 7'h49, 7'h49, 7'h06},   // 9
		35'd0,
		35'd0
	};

	typedef struct packed {
		logic              load;
		logic              clr_en;
		logic [ADDR_W-1:0] clr_addr;
		logic              step_en;
		logic [2:0]        step_col;
		logic              step_hi;
		logic              rd_en;
		logic              show;
	} cmd_t;

	function automatic logic [SLOT_W-1:0] glyph_slot(input logic [7:0] code);
		logic [SLOT_W-1:0] slot;
		slot = '0;
		if (code >= 8'h30 && code <= 8'h39) begin
			slot = SLOT_W'(code - 8'h30) + SLOT_W'(4);
		end else if (code == 8'h25) begin
			slot = SLOT_W'(1);
		end else if (code == 8'h2D) begin
			slot = SLOT_W'(2);
		end else if (code == 8'h2E) begin
			slot = SLOT_W'(3);
		end
		return slot;
	endfunction

endpackage

// ----- sv/grpf_ctrl.sv -----
module grpf_ctrl
	import grpf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	output logic       busy,
	output logic       done,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DRAW,
		ST_DRAIN,
		ST_READ,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [3:0]        step_q;
	logic              item_q;
	logic              done_q;

	localparam logic [3:0] LAST_STEP = 4'(2 * GLYPH_COLS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			step_q  <= '0;
			item_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
						if (item_q) begin
							state_q <= ST_DONE;
							done_q  <= 1'b1;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_IDLE: begin
					if (start) begin
						item_q <= 1'b1;
						step_q <= '0;
						cnt_q  <= '0;
						unique case (kind)
							KIND_CLEAR: state_q <= ST_CLEAR;
							KIND_DRAW:  state_q <= ST_DRAW;
							KIND_READ:  state_q <= ST_READ;
							default: begin
								state_q <= ST_DONE;
								done_q  <= 1'b1;
							end
						endcase
					end
				end
				ST_DRAW: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
					done_q  <= 1'b1;
				end
				ST_READ: begin
					state_q <= ST_DONE;
					done_q  <= 1'b1;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = start && (state_q == ST_IDLE);
		cmd.clr_en   = (state_q == ST_CLEAR);
		cmd.clr_addr = cnt_q;
		cmd.step_en  = (state_q == ST_DRAW);
		cmd.step_col = step_q[3:1];
		cmd.step_hi  = step_q[0];
		cmd.rd_en    = (state_q == ST_READ);
		cmd.show     = done_q;
	end

endmodule

// ----- sv/grpf_datapath.sv -----
module grpf_datapath
	import grpf_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [1:0]        kind,
	input  logic signed [7:0] pos_x,
	input  logic signed [6:0] pos_y,
	input  logic [7:0]        char_code,
	input  logic [9:0]        read_index,
	output logic [7:0]        read_data
);

	logic [7:0]        mem [STORE_DEPTH];
	logic [7:0]        rdata_q;

	logic [1:0]        kind_q;
	logic signed [7:0] x0_q;
	logic signed [6:0] y0_q;
	logic [SLOT_W-1:0] slot_q;
	logic [9:0]        index_q;

	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        mask_s1;

	logic [8:0]        px;
	logic signed [4:0] page;
	logic [7:0]        col_bits;
	logic [7:0]        mask;
	logic              col_ok;
	logic              step_ok;
	logic [ADDR_W-1:0] step_addr;
	logic [ADDR_W-1:0] rd_addr;
	int                idx;
	int                yv;
	int                rv;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			x0_q    <= pos_x;
			y0_q    <= pos_y;
			slot_q  <= glyph_slot(char_code);
			index_q <= read_index;
		end
	end

	// Column and page of the current step; the mask keeps only glyph rows on screen.
	always_comb begin
		px       = {x0_q[7], x0_q} + {6'd0, cmd.step_col};
		page     = {y0_q[6], y0_q[6:3]} + {4'd0, cmd.step_hi};
		col_bits = {1'b0, FONT_ROM[slot_q][7 * cmd.step_col +: 7]};
		col_ok   = !px[8] && (int'(px[7:0]) < SCREEN_WIDTH);
		for (int b = 0; b < 8; b++) begin
			yv      = int'(page) * 8 + b;
			rv      = yv - int'(y0_q);
			mask[b] = (rv >= 0) && (rv < GLYPH_ROWS) && col_bits[3'(rv)]
				&& (yv >= 0) && (yv < SCREEN_HEIGHT);
		end
		idx       = int'(px[7:0]) + int'(page[3:0]) * SCREEN_WIDTH;
		step_addr = ADDR_W'(idx);
		step_ok   = cmd.step_en && col_ok && !page[4] && (mask != 8'd0)
			&& (idx < STORE_DEPTH);
	end

	assign rd_addr = cmd.step_en ? step_addr : index_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= step_ok;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= step_addr;
		mask_s1 <= mask;
	end

	// Steps of one glyph hit distinct bytes, so the read of the next step
	// may share a cycle with the write-back of the previous one.
	always_ff @(posedge clk) begin
		if (cmd.step_en || cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (cmd.clr_en) begin
			mem[cmd.clr_addr] <= 8'd0;
		end else if (valid_s1) begin
			mem[addr_s1] <= rdata_q | mask_s1;
		end
	end

	assign read_data = (cmd.show && kind_q == KIND_READ) ? rdata_q : 8'd0;

endmodule

// ----- sv/glyph_rasterizer_page_framebuffer_core.sv -----
// Sequence: a read passes READ then DONE; a draw passes DRAW, DRAIN and DONE; a clear sweeps
// every store byte, then DONE; an unused kind goes straight to DONE. One item at a time: the next
// transfer lands in the cycle after done.
// Draw: ten overlapped read-modify-write steps (five columns, two pages each).
// Reset: arst_n clears control at once, then a sweep zeroes the store
// with busy high. done pulses one cycle per item; the receiver cannot stall.
module glyph_rasterizer_page_framebuffer_core
	import grpf_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  logic [1:0]        kind,
	input  logic signed [7:0] pos_x,
	input  logic signed [6:0] pos_y,
	input  logic [7:0]        char_code,
	input  logic [9:0]        read_index,
	output logic [7:0]        read_data
);

	// Commands from the sequencer to the store datapath: latch the item,
	// sweep the store, step through glyph columns, read a byte, show the result.
	cmd_t cmd;

	grpf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Datapath holds the frame store, the glyph ROM lookup and the
	// write-back stage; it drives read_data only on the done cycle of a read.
	grpf_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.char_code  (char_code),
		.read_index (read_index),
		.read_data  (read_data)
	);

endmodule

// ----- sv/grpf_checker.sv -----
module grpf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [7:0] read_data
);

	// A transfer always makes the block busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("busy not raised after transfer");

	// The result cycle belongs to the item in flight.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done while idle");

	// Release after the result is shown.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy && !done)
		else $error("busy held after done");

	// Read data is quiet outside the result cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !done |-> (read_data == 8'd0))
		else $error("read_data driven without done");

endmodule

bind glyph_rasterizer_page_framebuffer_core grpf_checker u_grpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.read_data (read_data)
);

// ----- bench/glyph_rasterizer_page_framebuffer_core_tb.sv -----
module glyph_rasterizer_page_framebuffer_core_tb;
	import grpf_pkg::*;

	// Kind code with no action in the block; the package names only three.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int FB_WIDTH    = 128;
	localparam int FB_HEIGHT   = 64;
	localparam int FB_BYTES    = 1024;
	localparam int CYCLE_LIMIT = 400000;
	// Longest single transfer is a clear; allow margin after drain.
	localparam int TAIL_CYCLES = 40;

	// 5x7 font, one 7-bit entry per column, bit r is glyph row r.
	// Slot 0 is blank: space and every code without a glyph.
	localparam logic [6:0] GLYPH_COLUMNS [14][5] = '{
		'{7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
		'{7'h63, 7'h13, 7'h08, 7'h64, 7'h63},
		'{7'h08, 7'h08, 7'h08, 7'h08, 7'h08},
		'{7'h00, 7'h60, 7'h60, 7'h00, 7'h00},
		'{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E},
		'{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
		'{7'h42, 7'h61, 7'h51, 7'h49, 7'h46},
		'{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31},
		'{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10},
		'{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
		'{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30},
		'{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
		'{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},
		'{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E}
	};

	// Codes that have a glyph; random draws mostly pick from these.
	localparam logic [7:0] DRAWN_CODES [14] = '{
		8'h20, 8'h25, 8'h2D, 8'h2E, 8'h30, 8'h31, 8'h32,
		8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
	};

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              done;
	logic [1:0]        kind;
	logic signed [7:0] pos_x;
	logic signed [6:0] pos_y;
	logic [7:0]        char_code;
	logic [9:0]        read_index;
	logic [7:0]        read_data;

	// Shadow copy of the page-layout framebuffer and the results owed by the block.
	logic [7:0] shadow_fb [FB_BYTES];
	logic [7:0] owed_bytes [$];

	int error_count;
	int cycle_count;
	int clear_count;
	int draw_count;
	int read_count;
	int unused_count;
	int lit_reads;
	int clipped_draws;

	// Sender pacing: burst length left, and whether gaps are allowed at all.
	int  burst_left;
	bit  gaps_on;

	// Remembered position of the last draw, so reads can aim at fresh pixels.
	int last_x;
	int last_y;

	glyph_rasterizer_page_framebuffer_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.done       (done),
		.kind       (kind),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.char_code  (char_code),
		.read_index (read_index),
		.read_data  (read_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("MISMATCH at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got,
			want);
	endtask

	// Map a character code to its font slot; anything unlisted is blank.
	function automatic int font_slot(input logic [7:0] code);
		int slot;
		slot = 0;
		if (code >= 8'h30 && code <= 8'h39) slot = 4 + int'(code - 8'h30);
		else if (code == 8'h25) slot = 1;
		else if (code == 8'h2D) slot = 2;
		else if (code == 8'h2E) slot = 3;
		return slot;
	endfunction

	// OR one glyph into the shadow framebuffer, skipping off-screen pixels.
	task automatic rasterize_glyph(input int x0, input int y0, input int slot);
		int px;
		int py;
		int idx;
		logic [6:0] bits;
		for (int c = 0; c < 5; c++) begin
			px = x0 + c;
			bits = GLYPH_COLUMNS[slot][c];
			if (px < 0 || px >= FB_WIDTH) continue;
			for (int r = 0; r < 7; r++) begin
				py = y0 + r;
				if (!bits[r]) continue;
				if (py < 0 || py >= FB_HEIGHT) continue;
				idx = px + (py / 8) * FB_WIDTH;
				if (idx >= FB_BYTES) continue;
				shadow_fb[idx] = shadow_fb[idx] | (8'd1 << (py % 8));
			end
		end
	endtask

	// Apply one accepted transfer to the shadow state and queue the byte it returns.
	task automatic predict_transfer(input logic [1:0] k, input logic signed [7:0] x,
			input logic signed [6:0] y, input logic [7:0] code, input logic [9:0] ri);
		logic [7:0] owed;
		int sx;
		int sy;
		owed = 8'h00;
		sx = int'(x);
		sy = int'(y);
		case (k)
			KIND_CLEAR: begin
				foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
				clear_count++;
			end
			KIND_DRAW: begin
				rasterize_glyph(sx, sy, font_slot(code));
				draw_count++;
				if (sx < 0 || sx > FB_WIDTH - 5 || sy < 0 || sy > FB_HEIGHT - 7)
					clipped_draws++;
			end
			KIND_READ: begin
				owed = shadow_fb[ri];
				read_count++;
				if (owed != 8'h00) lit_reads++;
			end
			default: unused_count++;
		endcase
		owed_bytes.push_back(owed);
	endtask

	// Check every done pulse against the oldest owed byte.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_bytes.size() == 0) begin
				report_mismatch("done with nothing owed, read_data", read_data, 0);
			end else begin
				if (read_data !== owed_bytes[0])
					report_mismatch("read_data", read_data, owed_bytes[0]);
				void'(owed_bytes.pop_front());
			end
		end
	end

	// Drive one item at the falling edge and hold it until the transfer.
	// Start stays high on return so a back-to-back item does not drop it.
	task automatic send_item(input logic [1:0] k, input logic [7:0] x, input logic [6:0] y,
			input logic [7:0] code, input logic [9:0] ri);
		kind       = k;
		pos_x      = x;
		pos_y      = y;
		char_code  = code;
		read_index = ri;
		start      = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_transfer(k, x, y, code, ri);
		@(negedge clk);
		if (k == KIND_DRAW) begin
			last_x = int'($signed(x));
			last_y = int'($signed(y));
		end
	endtask

	// When gaps are on, drop start for a random gap at the end of each burst.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 16);
		if (!gaps_on) return;
		gap = $urandom_range(0, 9);
		if (gap == 0) return;
		start = 1'b0;
		repeat (gap) @(negedge clk);
	endtask

	// Hold off the sender until every owed result has come back.
	task automatic drain_results();
		start = 1'b0;
		while (owed_bytes.size() != 0) @(negedge clk);
	endtask

	task automatic send_read(input logic [9:0] ri);
		send_item(KIND_READ, 8'($urandom), 7'($urandom), 8'($urandom), ri);
	endtask

	task automatic send_draw(input int x, input int y, input logic [7:0] code);
		send_item(KIND_DRAW, 8'(x), 7'(y), code, 10'($urandom));
	endtask

	// Pick a byte index under the last glyph when it is on screen, else anywhere.
	function automatic logic [9:0] aimed_index();
		int px;
		int py;
		px = last_x + $urandom_range(0, 4);
		py = last_y + $urandom_range(0, 6);
		if (px < 0 || px >= FB_WIDTH || py < 0 || py >= FB_HEIGHT) return 10'($urandom);
		return 10'(px + (py / 8) * FB_WIDTH);
	endfunction

	// The reset sweep must leave the store clear, including both end bytes.
	task automatic test_reset_clear();
		send_read(10'd0);
		send_read(10'd1023);
		send_read(10'($urandom));
	endtask

	// Every glyph, the clipping edges, blank codes, the unused kind and a clear.
	task automatic test_directed_glyphs();
		for (int d = 0; d < 10; d++) send_draw(d * 6, 0, 8'h30 + 8'(d));
		send_draw(64, 8, 8'h20);
		send_draw(70, 8, 8'h25);
		send_draw(76, 8, 8'h2D);
		send_draw(82, 8, 8'h2E);
		// Clip at the right and bottom edges, partly off the top left, fully off.
		send_draw(125, 60, 8'h38);
		send_draw(-3, -4, 8'h25);
		send_draw(-128, -64, 8'h31);
		// Codes without a glyph leave the store alone.
		send_draw(30, 30, 8'h41);
		send_draw(40, 40, 8'hFF);
		send_item(KIND_UNUSED, 8'hFF, 7'h7F, 8'hFF, 10'h3FF);
		send_read(10'd1);
		send_read(10'(FB_WIDTH + 71));
		send_read(10'd1023);
		send_read(10'd0);
		send_item(KIND_CLEAR, 8'h00, 7'h00, 8'h00, 10'h000);
		send_read(10'd1);
	endtask

	// Random text: mostly drawable glyphs near the screen and reads aimed at them.
	// A little noise: wild positions, any code, the unused kind, rare clears.
	task automatic test_random_text(input int count);
		int pick;
		int x;
		int y;
		logic [7:0] code;
		for (int n = 0; n < count; n++) begin
			// Alternate stretches of bursty and gap-free sending.
			if (n % 200 == 0) gaps_on = (n % 400 == 0);
			pick = $urandom_range(0, 999);
			if (pick < 4) begin
				send_item(KIND_CLEAR, 8'($urandom), 7'($urandom), 8'($urandom),
					10'($urandom));
			end else if (pick < 30) begin
				send_item(KIND_UNUSED, 8'($urandom), 7'($urandom), 8'($urandom),
					10'($urandom));
			end else if (pick < 520) begin
				x = ($urandom_range(0, 4) == 0) ? int'($signed(8'($urandom)))
					: $urandom_range(0, 135) - 8;
				y = ($urandom_range(0, 4) == 0) ? int'($signed(7'($urandom)))
					: $urandom_range(0, 71) - 8;
				code = ($urandom_range(0, 4) == 0) ? 8'($urandom)
					: DRAWN_CODES[$urandom_range(0, 13)];
				send_draw(x, y, code);
			end else if (pick < 800) begin
				send_read(aimed_index());
			end else begin
				send_read(10'($urandom));
			end
			pace_sender();
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		kind        = KIND_CLEAR;
		pos_x       = '0;
		pos_y       = '0;
		char_code   = '0;
		read_index  = '0;
		error_count = 0;
		cycle_count = 0;
		clear_count = 0;
		draw_count  = 0;
		read_count  = 0;
		unused_count = 0;
		lit_reads   = 0;
		clipped_draws = 0;
		burst_left  = 0;
		gaps_on     = 1'b0;
		last_x      = 0;
		last_y      = 0;
		foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_reset_clear();
		test_directed_glyphs();
		// Let everything settle once before the random part.
		drain_results();
		test_random_text(1280);

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d draws (%0d clipped), %0d reads (%0d nonzero), %0d clears,",
			draw_count, clipped_draws, read_count, lit_reads, clear_count);
		$display("and %0d unused-kind items; %0d mismatches", unused_count, error_count);
		if (error_count == 0 && owed_bytes.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
